// File: hdl/arc4_pkg.sv
// ----------------------------------------------------------------------------
// arc4_pkg
// Shared types and constants for the ARC4 keystream generator: item kinds,
// sequencer states and the request bundles sent to the two memories.
// ----------------------------------------------------------------------------
package arc4_pkg;

	localparam int PERM_DEPTH = 256;
	localparam int PERM_AW    = $clog2(PERM_DEPTH);
	localparam int KEY_DEPTH  = 256;
	localparam int KEY_AW     = $clog2(KEY_DEPTH);
	localparam int KEY_CW     = $clog2(KEY_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_RESET = 2'd0,
		KIND_KEY   = 2'd1,
		KIND_BYTE  = 2'd2,
		KIND_WORD  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_I,
		ST_RD_J,
		ST_WR_I,
		ST_WR_J
	} state_t;

	// Permutation memory: one read port, one write port, bulk restore to identity
	typedef struct packed {
		logic               rd_en;
		logic [PERM_AW-1:0] rd_addr;
		logic               wr_en;
		logic [PERM_AW-1:0] wr_addr;
		logic [7:0]         wr_data;
		logic               clr;
	} perm_req_t;

	// Key memory: one read port, one write port
	typedef struct packed {
		logic              rd_en;
		logic [KEY_AW-1:0] rd_addr;
		logic              wr_en;
		logic [KEY_AW-1:0] wr_addr;
		logic [7:0]        wr_data;
	} key_req_t;

endpackage

// File: hdl/arc4_perm_ram.sv
// ----------------------------------------------------------------------------
// arc4_perm_ram
// 256 x 8 permutation memory with registered read. A valid flag per entry
// lets the whole table fall back to identity at once: an entry not
// written since the last restore reads as its own address.
// ----------------------------------------------------------------------------
module arc4_perm_ram
	import arc4_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  perm_req_t  req,
	output logic [7:0] rd_data
);

	logic [7:0]            mem [PERM_DEPTH];
	logic [PERM_DEPTH-1:0] vld_q;
	logic [7:0]            mem_q;
	logic                  hit_q;
	logic [PERM_AW-1:0]    addr_q;

	// Write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Track written entries; restore clears every flag at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.clr) begin
			vld_q <= '0;
		end else if (req.wr_en) begin
			vld_q[req.wr_addr] <= 1'b1;
		end
	end

	// Registered read; hold the last word when no read is issued
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			mem_q  <= mem[req.rd_addr];
			hit_q  <= vld_q[req.rd_addr];
			addr_q <= req.rd_addr;
		end
	end

	assign rd_data = hit_q ? mem_q : 8'(addr_q);

endmodule

// File: hdl/arc4_key_ram.sv
// ----------------------------------------------------------------------------
// arc4_key_ram
// Key byte store with one write port and one registered read port.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module arc4_key_ram
	import arc4_pkg::*;
(
	input  logic       clk,
	input  key_req_t   req,
	output logic [7:0] rd_data
);

	logic [7:0] mem [KEY_DEPTH];
	logic [7:0] rd_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: hdl/arc4_core.sv
// ----------------------------------------------------------------------------
// arc4_core
// Sequencer and datapath: holds the indices, runs the key mix and the
// keystream swaps against the permutation memory, and owns the result
// register.
// ----------------------------------------------------------------------------
module arc4_core
	import arc4_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_kind,
	input  logic [7:0]  s_key_byte,
	input  logic        s_key_last,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_value,
	output logic        m_is_word,
	output perm_req_t   perm_req,
	input  logic [7:0]  perm_rd_data,
	output key_req_t    key_req,
	input  logic [7:0]  key_rd_data
);

	state_t            state_q, state_d;
	kind_t             kind;
	logic              accept;
	logic [7:0]        i_q, j_q, si_q, sj_q, t_q;
	logic              mix_q, word_q;
	logic [1:0]        cnt_q;
	logic [7:0]        rnd_q;
	logic [KEY_AW-1:0] kidx_q;
	logic [KEY_CW-1:0] key_count_q;
	logic [23:0]       acc_q;
	logic [7:0]        j_sum, ks_byte;
	logic              last_byte, out_free, hold, out_load, key_room, kidx_wrap;
	logic              m_tvalid_q;
	logic [31:0]       value_q;
	logic              is_word_q;

	assign kind      = kind_t'(s_kind);
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign key_room  = (key_count_q < KEY_CW'(KEY_DEPTH));
	assign kidx_wrap = ((KEY_CW'(kidx_q) + KEY_CW'(1)) == key_count_q);
	assign last_byte = !word_q || (cnt_q == 2'd3);
	assign out_free  = !m_tvalid_q || m_tready;
	assign hold      = (state_q == ST_WR_J) && !mix_q && last_byte && !out_free;
	assign out_load  = (state_q == ST_WR_J) && !mix_q && last_byte && out_free;
	assign j_sum     = j_q + perm_rd_data + (mix_q ? key_rd_data : 8'd0);

	// Output byte: forward the two swapped entries, else the memory word
	always_comb begin
		if (t_q == j_q) begin
			ks_byte = si_q;
		end else if (t_q == i_q) begin
			ks_byte = sj_q;
		end else begin
			ks_byte = perm_rd_data;
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory requests
	always_comb begin
		state_d          = state_q;
		perm_req.rd_en   = 1'b0;
		perm_req.rd_addr = i_q + 8'd1;
		perm_req.wr_en   = 1'b0;
		perm_req.wr_addr = i_q;
		perm_req.wr_data = perm_rd_data;
		perm_req.clr     = 1'b0;
		key_req.rd_en    = 1'b0;
		key_req.rd_addr  = kidx_q;
		key_req.wr_en    = 1'b0;
		key_req.wr_addr  = key_count_q[KEY_AW-1:0];
		key_req.wr_data  = s_key_byte;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (kind)
						KIND_RESET: perm_req.clr = 1'b1;
						KIND_KEY: begin
							key_req.wr_en = key_room;
							if (s_key_last) begin
								state_d = ST_RD_I;
							end
						end
						KIND_BYTE, KIND_WORD: state_d = ST_RD_I;
						default: ;
					endcase
				end
			end
			ST_RD_I: begin
				perm_req.rd_en = 1'b1;
				key_req.rd_en  = mix_q;
				state_d        = ST_RD_J;
			end
			ST_RD_J: begin
				perm_req.rd_en   = 1'b1;
				perm_req.rd_addr = j_sum;
				state_d          = ST_WR_I;
			end
			ST_WR_I: begin
				perm_req.rd_en   = !mix_q;
				perm_req.rd_addr = si_q + perm_rd_data;
				perm_req.wr_en   = 1'b1;
				state_d          = ST_WR_J;
			end
			ST_WR_J: begin
				perm_req.wr_en   = 1'b1;
				perm_req.wr_addr = j_q;
				perm_req.wr_data = si_q;
				if (!hold) begin
					if (mix_q) begin
						state_d = (rnd_q == 8'hff) ? ST_IDLE : ST_RD_I;
					end else begin
						state_d = last_byte ? ST_IDLE : ST_RD_I;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Indices, counters and key length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q         <= '0;
			j_q         <= '0;
			mix_q       <= 1'b0;
			word_q      <= 1'b0;
			cnt_q       <= '0;
			rnd_q       <= '0;
			kidx_q      <= '0;
			key_count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (kind)
							KIND_RESET: begin
								i_q <= '0;
								j_q <= '0;
							end
							KIND_KEY: begin
								if (key_room) begin
									key_count_q <= key_count_q + KEY_CW'(1);
								end
								if (s_key_last) begin
									mix_q  <= 1'b1;
									i_q    <= i_q - 8'd1;
									rnd_q  <= '0;
									kidx_q <= '0;
								end
							end
							default: begin
								mix_q  <= 1'b0;
								word_q <= (kind == KIND_WORD);
								cnt_q  <= '0;
							end
						endcase
					end
				end
				ST_RD_I: begin
					i_q <= i_q + 8'd1;
					if (mix_q) begin
						kidx_q <= kidx_wrap ? '0 : kidx_q + KEY_AW'(1);
					end
				end
				ST_RD_J: j_q <= j_sum;
				ST_WR_J: begin
					if (!hold) begin
						if (mix_q) begin
							rnd_q <= rnd_q + 8'd1;
							if (rnd_q == 8'hff) begin
								j_q         <= i_q;
								key_count_q <= '0;
							end
						end else begin
							cnt_q <= cnt_q + 2'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Swap operands and word accumulator
	always_ff @(posedge clk) begin
		if (state_q == ST_RD_J) begin
			si_q <= perm_rd_data;
		end
		if (state_q == ST_WR_I) begin
			sj_q <= perm_rd_data;
			t_q  <= si_q + perm_rd_data;
		end
		if (state_q == ST_WR_J && !mix_q && !hold) begin
			acc_q <= {acc_q[15:0], ks_byte};
		end
	end

	// Result register: load on the final byte, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q   <= word_q ? {acc_q, ks_byte} : {24'd0, ks_byte};
			is_word_q <= word_q;
		end
	end

	assign m_tvalid  = m_tvalid_q;
	assign m_value   = value_q;
	assign m_is_word = is_word_q;

	// A finished keystream item always lands in the result register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("result register not loaded");

	// The mix never runs with an empty key
	a_mix_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_I && mix_q) |-> (key_count_q != '0))
		else $error("key mix with zero key length");

	// The key index stays inside the stored key
	a_kidx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_I && mix_q) |-> (KEY_CW'(kidx_q) < key_count_q))
		else $error("key index beyond key length");

	// Equal indices must have read the same entry
	a_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR_J && i_q == j_q) |-> (si_q == sj_q))
		else $error("swap operands differ on one entry");

endmodule

// File: hdl/arc4_keystream_generator.sv
// ----------------------------------------------------------------------------
// arc4_keystream_generator
// ARC4 keystream generator with key scheduling.
// ----------------------------------------------------------------------------
// Items arrive on the slave stream with the kind in tuser, the key byte in
// tdata and the final-key mark in tlast. A reset item and a plain key byte
// are handled at acceptance and leave the sequencer idle. For a keystream
// byte or word the item is accepted, then each byte runs a read of S[i], a read
// of S[j], a write of S[i] and a write of S[j] through the single read port
// and single write port of the permutation memory. A key byte marked last
// is accepted and then runs 256 rounds of these steps. A finished result
// waits in an output register while the next item is accepted; a keystream
// item that ends while that register is still full waits for it. Keystream
// bytes of a word come out first byte in bits 31 to 24.
// ----------------------------------------------------------------------------
module arc4_keystream_generator
	import arc4_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] key_byte
	input  logic [1:0]  s_axis_tuser,  // [1:0] kind
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] value
	output logic [0:0]  m_axis_tuser   // [0] is_word
);

	perm_req_t  perm_req;
	key_req_t   key_req;
	logic [7:0] perm_rd_data;
	logic [7:0] key_rd_data;
	logic       is_word;

	arc4_perm_ram u_perm_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (perm_req),
		.rd_data (perm_rd_data)
	);

	arc4_key_ram u_key_ram (
		.clk     (clk),
		.req     (key_req),
		.rd_data (key_rd_data)
	);

	arc4_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_axis_tvalid),
		.s_tready     (s_axis_tready),
		.s_kind       (s_axis_tuser),
		.s_key_byte   (s_axis_tdata),
		.s_key_last   (s_axis_tlast),
		.m_tvalid     (m_axis_tvalid),
		.m_tready     (m_axis_tready),
		.m_value      (m_axis_tdata),
		.m_is_word    (is_word),
		.perm_req     (perm_req),
		.perm_rd_data (perm_rd_data),
		.key_req      (key_req),
		.key_rd_data  (key_rd_data)
	);

	assign m_axis_tuser = is_word;

endmodule
